[hdl/shell_argument_tokenizer_assert.svh]
// Assertion macros for the argument tokenizer.
`ifndef SHELL_ARGUMENT_TOKENIZER_ASSERT_SVH
`define SHELL_ARGUMENT_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SAT_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tokenizer check failed");
`define SAT_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tokenizer check failed");
`else
`define SAT_ASSERT_IMP(label, pre, post)
`define SAT_ASSERT_NXT(label, pre, post)
`endif
`endif

[hdl/sat_pkg.sv]
package sat_pkg;

    localparam int HOLD_DEPTH = 30;
    localparam int MAX_ARGS   = 64;

    localparam int HW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(MAX_ARGS + 1);

    localparam int IDX_W   = 6;
    localparam int IDX_SAT = (1 << IDX_W) - 1;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_FLUSH_RD,
        ST_FLUSH_WR,
        ST_CLOSE
    } state_t;

    typedef enum logic [1:0] {
        B_NONE,
        B_APPEND,
        B_CLOSE
    } b_kind_t;

    typedef struct packed {
        logic sq;
        logic dq;
        logic nested;
        logic ppend;
        logic qpend;
    } flags_t;

    typedef struct packed {
        logic open;
        logic seen;
        logic held_full;
        logic args_full;
    } ctx_t;

    typedef struct packed {
        logic    a_present;
        b_kind_t b_kind;
        logic    b_emits;
        flags_t  flags_next;
    } plan_t;

    typedef struct packed {
        logic             char_valid;
        logic [7:0]       out_char;
        logic             arg_end;
        logic [IDX_W-1:0] arg_index;
        logic             line_end;
        logic             args_overflow;
        logic             space_overflow;
        logic             last;
    } res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {[CH_TAB:CH_CR], CH_SPACE};
    endfunction

    function automatic logic escapable(input logic [7:0] c);
        return c inside {CH_DOLLAR, CH_BSLASH, CH_BTICK, CH_DQUOTE, CH_SQUOTE};
    endfunction

endpackage

[hdl/shell_argument_tokenizer.sv]
// A character is taken while idle; each of its results is registered in the output
// register once that register is free. Flushing held whitespace first checks the fill
// count, then reads the memory and outputs each held character in turn.
// One character is in work at a time: no new one is taken until the last is through.
// Reset: rst_n asynchronous, active low; clears modes, counts and the output valid flag.
// The whitespace memory is not cleared: it is only read below the fill count.
module shell_argument_tokenizer
    import sat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
    input  logic        s_axis_tlast,   // end_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_char, [13:8] arg_index, [15:14] zero
    output logic [4:0]  m_axis_tuser,   // char_valid, arg_end, line_end, args_overflow,
                                        // space_overflow
    output logic        m_axis_tlast    // last
);

`include "shell_argument_tokenizer_assert.svh"

    state_t         state_reg, state_next;
    flags_t         flags_reg, flags_next;
    logic           open_reg, open_next;
    logic           seen_reg, seen_next;
    logic [HW-1:0]  held_reg, held_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [7:0]     ap_char_reg, ap_char_next;
    logic [7:0]     char_reg, char_next;
    logic           eol_reg, eol_next;
    logic           phase_b_reg, phase_b_next;
    b_kind_t        kind_reg, kind_next;
    logic           b_emits_reg, b_emits_next;
    res_t           out_reg;
    logic           out_valid_reg;

    logic [7:0]     hold_mem [HOLD_DEPTH];
    logic [7:0]     rd_data_reg;
    logic           ram_we, ram_re;

    ctx_t           ctx;
    plan_t          plan;
    res_t           res;
    logic           emit, ap_done, slot_free, args_full, held_full;
    logic           in_flush, eol_take;
    logic [IDX_W-1:0] arg_idx;

    assign args_full = count_reg >= CW'(MAX_ARGS);
    assign held_full = held_reg == HW'(HOLD_DEPTH);
    assign arg_idx   = (32'(count_reg) >= 32'(IDX_SAT)) ? IDX_W'(IDX_SAT)
                                                         : IDX_W'(count_reg);
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign in_flush  = state_reg == ST_FLUSH_RD || state_reg == ST_FLUSH_WR;
    assign eol_take  = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    assign ctx.open      = open_reg;
    assign ctx.seen      = seen_reg;
    assign ctx.held_full = held_full;
    assign ctx.args_full = args_full;

    sat_decode u_decode (
        .in_char (s_axis_tdata),
        .eol     (s_axis_tlast),
        .flags   (flags_reg),
        .ctx     (ctx),
        .plan    (plan)
    );

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            hold_mem[held_reg[AW-1:0]] <= ap_char_reg;
        end
        if (ram_re)
        begin
            rd_data_reg <= hold_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flags_reg     <= '0;
            open_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            held_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flags_reg <= flags_next;
            open_reg  <= open_next;
            seen_reg  <= seen_next;
            held_reg  <= held_next;
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        ap_char_reg <= ap_char_next;
        char_reg    <= char_next;
        eol_reg     <= eol_next;
        phase_b_reg <= phase_b_next;
        kind_reg    <= kind_next;
        b_emits_reg <= b_emits_next;
        if (emit)
        begin
            out_reg <= res;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        flags_next    = flags_reg;
        open_next     = open_reg;
        seen_next     = seen_reg;
        held_next     = held_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        ap_char_next  = ap_char_reg;
        char_next     = char_reg;
        eol_next      = eol_reg;
        phase_b_next  = phase_b_reg;
        kind_next     = kind_reg;
        b_emits_next  = b_emits_reg;
        s_axis_tready = 1'b0;
        emit          = 1'b0;
        ap_done       = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        res           = '0;
        res.arg_index = arg_idx;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    char_next    = s_axis_tdata;
                    eol_next     = s_axis_tlast;
                    flags_next   = plan.flags_next;
                    kind_next    = plan.b_kind;
                    b_emits_next = plan.b_emits;
                    phase_b_next = !plan.a_present;
                    ap_char_next = plan.a_present ? CH_BSLASH : s_axis_tdata;
                    if (plan.a_present || plan.b_kind == B_APPEND)
                    begin
                        state_next = ST_APPEND;
                    end
                    else if (plan.b_kind == B_CLOSE)
                    begin
                        state_next = ST_CLOSE;
                    end
                end
            end

            ST_APPEND:
            begin
                res.last = phase_b_reg || !b_emits_reg;
                if (args_full)
                begin
                    open_next = 1'b1;
                    ap_done   = 1'b1;
                end
                else if (is_ws(ap_char_reg))
                begin
                    if (!seen_reg)
                    begin
                        open_next = 1'b1;
                        ap_done   = 1'b1;
                    end
                    else if (!held_full)
                    begin
                        ram_we    = 1'b1;
                        held_next = held_reg + HW'(1);
                        open_next = 1'b1;
                        ap_done   = 1'b1;
                    end
                    else if (slot_free)
                    begin
                        res.space_overflow = 1'b1;
                        emit      = 1'b1;
                        open_next = 1'b1;
                        ap_done   = 1'b1;
                    end
                end
                else if (held_reg != '0)
                begin
                    idx_next   = '0;
                    state_next = ST_FLUSH_RD;
                end
                else if (slot_free)
                begin
                    res.char_valid = 1'b1;
                    res.out_char   = ap_char_reg;
                    emit      = 1'b1;
                    seen_next = 1'b1;
                    open_next = 1'b1;
                    ap_done   = 1'b1;
                end
            end

            ST_FLUSH_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_FLUSH_WR;
            end

            ST_FLUSH_WR:
            begin
                if (slot_free)
                begin
                    res.char_valid = 1'b1;
                    res.out_char   = rd_data_reg;
                    emit = 1'b1;
                    if (HW'(idx_reg) + HW'(1) == held_reg)
                    begin
                        held_next  = '0;
                        state_next = ST_APPEND;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_FLUSH_RD;
                    end
                end
            end

            ST_CLOSE:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    res.last      = 1'b1;
                    res.line_end  = eol_reg;
                    if (open_reg)
                    begin
                        res.arg_end       = 1'b1;
                        res.args_overflow = args_full;
                        if (!args_full)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    if (eol_reg)
                    begin
                        count_next = '0;
                    end
                    open_next  = 1'b0;
                    seen_next  = 1'b0;
                    held_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ap_done)
        begin
            if (!phase_b_reg && kind_reg == B_APPEND)
            begin
                ap_char_next = char_reg;
                phase_b_next = 1'b1;
                state_next   = ST_APPEND;
            end
            else if (!phase_b_reg && kind_reg == B_CLOSE)
            begin
                state_next = ST_CLOSE;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.arg_index, out_reg.out_char};
    assign m_axis_tuser  = {out_reg.space_overflow, out_reg.args_overflow,
                            out_reg.line_end, out_reg.arg_end, out_reg.char_valid};
    assign m_axis_tlast  = out_reg.last;

    `SAT_ASSERT_IMP(a_held_bound, 1'b1, held_reg <= HW'(HOLD_DEPTH))
    `SAT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(MAX_ARGS))
    `SAT_ASSERT_IMP(a_flush_nonempty, in_flush, held_reg != '0)
    `SAT_ASSERT_IMP(a_line_end_last, out_valid_reg && out_reg.line_end, out_reg.last)
    `SAT_ASSERT_NXT(a_eol_runs, eol_take, state_reg == ST_APPEND || state_reg == ST_CLOSE)

endmodule

[hdl/sat_decode.sv]
module sat_decode
    import sat_pkg::*;
(
    input  logic [7:0] in_char,
    input  logic       eol,
    input  flags_t     flags,
    input  ctx_t       ctx,
    output plan_t      plan
);

    logic    normal;
    logic    a_present;
    b_kind_t kind;
    flags_t  fn;

    always_comb
    begin
        fn        = flags;
        a_present = 1'b0;
        kind      = B_NONE;
        normal    = 1'b0;
        if (eol)
        begin
            a_present = flags.qpend;
            kind      = B_CLOSE;
            fn        = '0;
        end
        else if (flags.qpend)
        begin
            fn.qpend = 1'b0;
            if (escapable(in_char))
            begin
                kind = B_APPEND;
            end
            else
            begin
                a_present = 1'b1;
                normal    = 1'b1;
            end
        end
        else if (flags.ppend)
        begin
            fn.ppend = 1'b0;
            kind     = B_APPEND;
        end
        else
        begin
            normal = 1'b1;
        end

        if (normal)
        begin
            if (in_char == CH_DQUOTE && !flags.sq)
            begin
                fn.dq = !flags.dq;
            end
            else if (in_char == CH_SQUOTE && !flags.dq)
            begin
                fn.sq = !flags.sq;
            end
            else
            begin
                if (in_char == CH_SQUOTE)
                begin
                    fn.nested = !flags.nested;
                end
                if (in_char == CH_SPACE && !flags.sq && !flags.dq)
                begin
                    kind = (ctx.open || a_present) ? B_CLOSE : B_NONE;
                end
                else if (in_char == CH_BSLASH && flags.dq && !flags.nested)
                begin
                    fn.qpend = 1'b1;
                end
                else if (in_char == CH_BSLASH && !flags.dq && !flags.sq)
                begin
                    fn.ppend = 1'b1;
                end
                else
                begin
                    kind = B_APPEND;
                end
            end
        end

        plan.a_present  = a_present;
        plan.b_kind     = kind;
        plan.flags_next = fn;
        // after a backslash append the hold buffer is empty, so no overflow result
        plan.b_emits    = (kind == B_CLOSE)
                       || (kind == B_APPEND && !ctx.args_full
                           && (!is_ws(in_char)
                               || (!a_present && ctx.seen && ctx.held_full)));
    end

endmodule
